[hdl/ofcc_pkg.sv]
// Shared types, constants and the CRC-8 byte update for the 1-wire frame checker.
`default_nettype none

package ofcc_pkg;

    // Reflected CRC-8 polynomial x^8+x^5+x^4+1.
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Index of the CRC byte for each frame kind.
    localparam logic [3:0] SCRATCH_LAST = 4'd8;
    localparam logic [3:0] ROM_LAST     = 4'd7;

    // Frame kind register codes.
    localparam logic KIND_SCRATCH = 1'b0;
    localparam logic KIND_ROM     = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_LINK_ERR = 2'd1;
    localparam logic [1:0] STATUS_CRC_ERR  = 2'd2;

    // One accepted input item.
    typedef struct packed {
        logic       rx_fail;
        logic [7:0] rx_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0]         computed_crc;
        logic signed [15:0] temperature_sixteenths;
        logic [1:0]         status;
    } t_result;

    // Eight-step bitwise CRC-8 update over one byte.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/ofcc_in_stage.sv]
// Input register of the frame checker: holds one accepted item until the evaluation step.
`default_nettype none

module ofcc_in_stage
    import ofcc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    input  wire logic     i_advance,
    output logic          o_valid,
    output t_in_item      o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     w_accept;

    // The register takes a new item when empty or when its item moves on.
    assign o_ready  = !r_valid || i_advance;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    // Valid flag is control state; the item payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    // A held item that cannot move on stays held.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_advance) |=> (r_valid && $stable(r_item)))
        else $error("input stage lost a stalled item");

endmodule

`default_nettype wire

[hdl/ofcc_frame_eval.sv]
// Frame state, CRC update and result decision for one item per step.
`default_nettype none

module ofcc_frame_eval
    import ofcc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_wr_en,
    input  wire logic     i_cfg_wr_data,
    input  wire logic     i_step,
    input  wire t_in_item i_item,
    output logic          o_res_valid,
    output t_result       o_result
);

    logic       r_frame_kind;
    logic [7:0] r_crc;
    logic [3:0] r_pos;
    logic [7:0] r_temp_lo;
    logic [7:0] r_temp_hi;

    logic [7:0] n_crc;
    logic [3:0] n_pos;
    logic [7:0] n_temp_lo;
    logic [7:0] n_temp_hi;

    logic [3:0] w_last;
    logic [7:0] w_crc_upd;

    // Frame kind register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_kind <= KIND_SCRATCH;
        end else if (i_cfg_wr_en) begin
            r_frame_kind <= i_cfg_wr_data;
        end
    end

    assign w_last    = (r_frame_kind == KIND_ROM) ? ROM_LAST : SCRATCH_LAST;
    assign w_crc_upd = crc8_byte(r_crc, i_item.rx_byte);

    // Decide whether this item is a data byte, the CRC byte or a read failure.
    always_comb begin
        n_crc       = r_crc;
        n_pos       = r_pos;
        n_temp_lo   = r_temp_lo;
        n_temp_hi   = r_temp_hi;
        o_res_valid = 1'b0;
        o_result.status                 = STATUS_OK;
        o_result.temperature_sixteenths = '0;
        o_result.computed_crc           = r_crc;
        if (i_item.rx_fail) begin
            o_res_valid     = 1'b1;
            o_result.status = STATUS_LINK_ERR;
            n_crc     = '0;
            n_pos     = '0;
            n_temp_lo = '0;
            n_temp_hi = '0;
        end else if (r_pos < w_last) begin
            if (r_pos == 4'd0) begin
                n_temp_lo = i_item.rx_byte;
            end else if (r_pos == 4'd1) begin
                n_temp_hi = i_item.rx_byte;
            end
            n_crc = w_crc_upd;
            n_pos = r_pos + 4'd1;
        end else begin
            o_res_valid = 1'b1;
            if (i_item.rx_byte == r_crc) begin
                o_result.status = STATUS_OK;
                if (r_frame_kind == KIND_SCRATCH) begin
                    o_result.temperature_sixteenths = {r_temp_hi, r_temp_lo};
                end
            end else begin
                o_result.status = STATUS_CRC_ERR;
            end
            n_crc     = '0;
            n_pos     = '0;
            n_temp_lo = '0;
            n_temp_hi = '0;
        end
    end

    // Frame state advances only when an item is evaluated.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= '0;
            r_pos     <= '0;
            r_temp_lo <= '0;
            r_temp_hi <= '0;
        end else if (i_step) begin
            r_crc     <= n_crc;
            r_pos     <= n_pos;
            r_temp_lo <= n_temp_lo;
            r_temp_hi <= n_temp_hi;
        end
    end

    // The byte position never passes the longest frame's CRC index.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= SCRATCH_LAST)
        else $error("byte position out of range");

    // Any step that ends a frame leaves a cleared frame behind.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid) |=> (r_pos == 4'd0 && r_crc == 8'd0))
        else $error("frame state not cleared after result");

    // Temperature is reported only with a good CRC.
    a_temp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result.status != STATUS_OK)
            |-> (o_result.temperature_sixteenths == 16'sd0))
        else $error("temperature reported on a failed frame");

endmodule

`default_nettype wire

[hdl/ofcc_out_stage.sv]
// Result register of the frame checker, loaded when empty or while the previous result is taken.
`default_nettype none

module ofcc_out_stage
    import ofcc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_can_load,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // Free when empty or when the waiting result is taken this cycle.
    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[hdl/onewire_frame_crc_checker_core.sv]
// Top level of the 1-wire frame CRC-8 checker.
// A frame's result is loaded into the result register as its last item is evaluated.
// Throughput: one item per cycle; the input register and the result register
// advance together, so the rate is set only by the result side taking its items.
// Reset: synchronous active-low i_rst_n clears the frame state, sets the frame
// kind to scratchpad and empties both registers.
`default_nettype none

module onewire_frame_crc_checker_core
    import ofcc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: frame kind.
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data,
    // Input items.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tuser,   // [0] rx_fail
    // Result items.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [1:0] status, [17:2] temperature_sixteenths,
                                             // [25:18] computed_crc, [31:26] zero
);

    t_in_item w_in_item;
    t_in_item w_held_item;
    logic     w_held_valid;
    logic     w_advance;
    logic     w_can_load;
    logic     w_res_valid;
    t_result  w_result;
    t_result  w_out_result;

    assign w_in_item.rx_byte = s_axis_tdata;
    assign w_in_item.rx_fail = s_axis_tuser;

    // An item is evaluated when the result register can take what it causes.
    assign w_advance = w_held_valid && w_can_load;

    ofcc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_held_valid),
        .o_item    (w_held_item)
    );

    ofcc_frame_eval u_frame_eval (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (w_advance),
        .i_item        (w_held_item),
        .o_res_valid   (w_res_valid),
        .o_result      (w_result)
    );

    ofcc_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_advance && w_res_valid),
        .i_result   (w_result),
        .o_can_load (w_can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (w_out_result)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {6'd0, w_out_result.computed_crc,
                           w_out_result.temperature_sixteenths, w_out_result.status};

endmodule

`default_nettype wire

[tb/ofcc_frame_checker.sv]
// Checker for the 1-wire frame CRC-8 checker: watches both item channels, predicts and compares.

module ofcc_frame_checker
    import ofcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,     // [7:0] rx_byte
    input  logic        i_in_user,     // [0] rx_fail
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,    // [1:0] status, [17:2] temperature, [25:18] crc
    output int          o_fail_count,
    output int          o_pending,
    output int          o_ok_count,
    output int          o_link_count,
    output int          o_crc_err_count,
    output logic        o_crc_due,
    output logic [7:0]  o_running_crc
);

    // Predicted copy of the frame state and the frame kind register.
    logic       kind;
    logic [7:0] crc_acc;
    logic [3:0] next_pos;
    logic [7:0] temp_lo;
    logic [7:0] temp_hi;
    t_result    frame_verdicts_q[$];

    // The stimulus uses these to end frames with a correct or a corrupted CRC byte.
    assign o_running_crc = crc_acc;
    assign o_crc_due     = next_pos >= ((kind == KIND_ROM) ? ROM_LAST : SCRATCH_LAST);

    // Reflected CRC-8, one data bit per step starting with the least significant.
    function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        logic       feedback;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            feedback = c[0] ^ b[i];
            c = c >> 1;
            if (feedback) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic restart_frame();
        crc_acc  = 8'h00;
        next_pos = 4'd0;
        temp_lo  = 8'h00;
        temp_hi  = 8'h00;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        o_fail_count++;
    endtask

    // Advance the frame by one accepted item and queue the verdict if the frame ends.
    task automatic absorb_item(input logic [7:0] b, input logic rx_fail);
        t_result    verdict;
        logic [3:0] crc_pos;
        crc_pos = (kind == KIND_ROM) ? ROM_LAST : SCRATCH_LAST;
        verdict = '0;
        verdict.computed_crc = crc_acc;
        if (rx_fail) begin
            verdict.status = STATUS_LINK_ERR;
        end else if (next_pos < crc_pos) begin
            if (next_pos == 4'd0) begin
                temp_lo = b;
            end else if (next_pos == 4'd1) begin
                temp_hi = b;
            end
            crc_acc  = crc_fold(crc_acc, b);
            next_pos = next_pos + 4'd1;
            return;
        end else if (b == crc_acc) begin
            verdict.status = STATUS_OK;
            if (kind == KIND_SCRATCH) begin
                verdict.temperature_sixteenths = {temp_hi, temp_lo};
            end
        end else begin
            verdict.status = STATUS_CRC_ERR;
        end
        frame_verdicts_q.push_back(verdict);
        restart_frame();
    endtask

    // Compare one result item with the oldest expected verdict.
    task automatic check_result(input logic [31:0] word);
        t_result got;
        t_result want;
        got = t_result'(word[25:0]);
        if (frame_verdicts_q.size() == 0) begin
            report_mismatch($sformatf("result item 0x%08h arrived with none expected", word));
            return;
        end
        want = frame_verdicts_q.pop_front();
        if (got.status != want.status) begin
            report_mismatch($sformatf("status is %0d, expected %0d", got.status, want.status));
        end
        if (got.temperature_sixteenths != want.temperature_sixteenths) begin
            report_mismatch($sformatf("temperature is 0x%04h, expected 0x%04h",
                got.temperature_sixteenths, want.temperature_sixteenths));
        end
        if (got.computed_crc != want.computed_crc) begin
            report_mismatch($sformatf("computed CRC is 0x%02h, expected 0x%02h",
                got.computed_crc, want.computed_crc));
        end
        if (word[31:26] != 6'd0) begin
            report_mismatch($sformatf("padding bits are 0x%02h, expected zero", word[31:26]));
        end
        if (want.status == STATUS_OK) begin
            o_ok_count++;
        end else if (want.status == STATUS_LINK_ERR) begin
            o_link_count++;
        end else begin
            o_crc_err_count++;
        end
    endtask

    // Results are checked before the input of the same edge is absorbed; the block's
    // latency keeps an item from producing its result at the edge that accepts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kind = KIND_SCRATCH;
            restart_frame();
            frame_verdicts_q.delete();
            o_fail_count    = 0;
            o_ok_count      = 0;
            o_link_count    = 0;
            o_crc_err_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_data);
            end
            if (i_in_valid && i_in_ready) begin
                absorb_item(i_in_data, i_in_user);
            end
            if (i_cfg_wr_en) begin
                kind = i_cfg_wr_data;
            end
        end
        o_pending = frame_verdicts_q.size();
    end

endmodule

[tb/tb.sv]
// Testbench top for the 1-wire frame CRC-8 checker: clock, reset, stimulus and verdict.

module tb
    import ofcc_pkg::*;
();

    localparam int RANDOM_ITEMS = 650;
    localparam int HOLD_CYCLES  = 80;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    int          fail_count;
    int          pending_count;
    int          ok_count;
    int          link_count;
    int          crc_err_count;
    logic        crc_due;
    logic [7:0]  running_crc;

    int          items_sent       = 0;
    int          settings_written = 0;
    logic        src_calm         = 1'b0;
    logic        rx_calm          = 1'b0;
    logic        rx_hold_req      = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    onewire_frame_crc_checker_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ofcc_frame_checker u_frame_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (s_axis_tvalid),
        .i_in_ready      (s_axis_tready),
        .i_in_data       (s_axis_tdata),
        .i_in_user       (s_axis_tuser),
        .i_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .i_out_data      (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count),
        .o_ok_count      (ok_count),
        .o_link_count    (link_count),
        .o_crc_err_count (crc_err_count),
        .o_crc_due       (crc_due),
        .o_running_crc   (running_crc)
    );

    // Offer one item after a random gap and return at the falling edge after it is taken.
    task automatic push_item(input logic [7:0] b, input logic rx_fail);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tuser  = rx_fail;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Finish the current frame: temperature bytes first, then random data, then the CRC
    // byte xored with crc_xor. A read failure replaces the item at index fail_at.
    task automatic send_frame(input logic [15:0] temp, input logic [7:0] crc_xor,
                              input int fail_at);
        int         idx;
        logic [7:0] b;
        idx = 0;
        while (!crc_due && idx != fail_at) begin
            b = (idx == 0) ? temp[7:0] : (idx == 1) ? temp[15:8] : 8'($urandom);
            push_item(b, 1'b0);
            idx++;
        end
        if (idx == fail_at) begin
            push_item(8'($urandom), 1'b1);
        end else begin
            push_item(running_crc ^ crc_xor, 1'b0);
        end
    endtask

    // Send up to n data bytes and leave the frame open.
    task automatic send_partial(input int n);
        for (int k = 0; k < n && !crc_due; k++) begin
            push_item(8'($urandom), 1'b0);
        end
    endtask

    // Stop offering items until every verdict is back and the pipeline has emptied.
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_kind(input logic k);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = k;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        settings_written++;
    endtask

    // Result side: random stalls, calm stretches, and one long hold-off on request.
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (rx_hold_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            if ($urandom_range(0, 39) == 0) begin
                rx_calm = !rx_calm;
            end
            gap = rx_calm ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // Main stimulus.
    initial begin
        int          phase;
        int          pick;
        int          target;
        logic [15:0] temp;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_kind(KIND_SCRATCH);

        // Directed: coldest reading, a failure on the first byte, a failure mid-frame,
        // and a switch to ROM mode after eight data bytes so the next byte is the CRC.
        send_frame(16'h8000, 8'h00, -1);
        push_item(8'hFF, 1'b1);
        send_frame(16'h7FFF, 8'h00, 4);
        push_item(8'hFF, 1'b0);
        push_item(8'h7F, 1'b0);
        send_partial(6);
        drain_results();
        write_kind(KIND_ROM);
        push_item(running_crc ^ 8'h80, 1'b0);

        // Random phases, each under a fresh frame kind, mostly well-formed frames.
        target = items_sent + RANDOM_ITEMS;
        phase  = 0;
        while (items_sent < target) begin
            drain_results();
            write_kind(1'($urandom_range(0, 1)));
            src_calm = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // Back-to-back failures while the result side holds off fill the block.
                src_calm    = 1'b1;
                rx_hold_req = 1'b1;
                repeat (16) push_item(8'($urandom), 1'b1);
            end
            repeat ($urandom_range(3, 8)) begin
                case ($urandom_range(0, 7))
                    0:       temp = 16'h8000;
                    1:       temp = 16'h7FFF;
                    2:       temp = 16'hFFFF;
                    3:       temp = 16'h0000;
                    default: temp = 16'($urandom);
                endcase
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_frame(temp, 8'h00, -1);
                end else if (pick < 82) begin
                    send_frame(temp, 8'($urandom_range(1, 255)), -1);
                end else if (pick < 94) begin
                    send_frame(temp, 8'h00, $urandom_range(0, 8));
                end else begin
                    repeat ($urandom_range(1, 3)) begin
                        push_item(8'($urandom), 1'($urandom_range(0, 1)));
                    end
                end
            end
            // Sometimes leave a frame open so the next kind change lands mid-frame.
            if ($urandom_range(0, 1) == 1) begin
                send_partial($urandom_range(1, 8));
            end
            phase++;
        end
        drain_results();

        $display("Sent %0d bytes under %0d frame-kind writes, with read failures and CRC faults.",
            items_sent, settings_written);
        $display("Checked verdicts: %0d ok, %0d link error, %0d CRC mismatch.",
            ok_count, link_count, crc_err_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake or verdicts that never arrive.
    initial begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
hdl/ofcc_pkg.sv
hdl/ofcc_in_stage.sv
hdl/ofcc_frame_eval.sv
hdl/ofcc_out_stage.sv
hdl/onewire_frame_crc_checker_core.sv
tb/ofcc_frame_checker.sv
tb/tb.sv
